// ===== design/phwbb_pkg.sv =====
`default_nettype none
package phwbb_pkg;

  localparam int unsigned SamplesDefault = 10;

  localparam int unsigned AdcW    = 10;
  localparam int unsigned PhW     = 12;
  localparam int unsigned BandW   = 10;
  localparam int unsigned GainW   = 16;
  localparam int unsigned OffsetW = 13;
  localparam int unsigned CountW  = 4;
  localparam int unsigned SumW    = 16;
  localparam int unsigned NumW    = SumW + 1;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 16;

  // reciprocal divide: q = (n * ceil(2^DivShift / d)) >> DivShift, exact for n < 2^NumW, d <= 14
  localparam int unsigned DivShift = 22;
  localparam int unsigned RecipW   = 21;

  localparam logic [PhW-1:0]            TargetReset = 12'd0;
  localparam logic [BandW-1:0]          BandReset   = 10'd102;
  localparam logic signed [GainW-1:0]   GainReset   = 16'sd291;
  localparam logic signed [OffsetW-1:0] OffsetReset = 13'sd195;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET = 4'd0,
    CFG_BAND   = 4'd1,
    CFG_GAIN   = 4'd2,
    CFG_OFFSET = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PhW-1:0]            target;
    logic [BandW-1:0]          band;
    logic signed [GainW-1:0]   gain;
    logic signed [OffsetW-1:0] offset;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/phwbb_if.sv =====
`default_nettype none
interface phwbb_sample_if import phwbb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [AdcW-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface phwbb_result_if import phwbb_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [PhW-1:0] ph_average;
  logic           acid_on;
  logic           base_on;

  modport source (output valid, output ph_average, output acid_on, output base_on,
                  input ready);
  modport sink   (input valid, input ph_average, input acid_on, input base_on,
                  output ready);
endinterface

interface phwbb_cfg_if import phwbb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/phwbb_convert.sv =====
`default_nettype none
module phwbb_convert import phwbb_pkg::*; (
  input  wire logic [AdcW-1:0] adc_i,
  input  wire cfg_t            cfg_i,
  output logic [PhW-1:0]       ph_o
);

  logic signed [26:0] prod;
  logic signed [26:0] rounded;
  logic signed [18:0] scaled;
  logic signed [19:0] sum;

  assign prod    = $signed({1'b0, adc_i}) * cfg_i.gain;
  assign rounded = prod + 27'sd128;
  assign scaled  = rounded[26:8];
  assign sum     = {scaled[18], scaled} + {{(20-OffsetW){cfg_i.offset[OffsetW-1]}}, cfg_i.offset};

  always_comb begin
    if (sum[19]) begin
      ph_o = '0;
    end else if (sum[18:PhW] != '0) begin
      ph_o = '1;
    end else begin
      ph_o = sum[PhW-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== design/phwbb_divide.sv =====
`default_nettype none
module phwbb_divide import phwbb_pkg::*; #(
  parameter int unsigned Samples = SamplesDefault
) (
  input  wire logic [NumW-1:0] num_i,
  output logic [PhW-1:0]       quot_o
);

  localparam int unsigned Div = Samples - 2;
  localparam logic [RecipW-1:0] Recip = RecipW'(((1 << DivShift) + Div - 1) / Div);

  logic [NumW+RecipW-1:0] prod;

  assign prod   = {{RecipW{1'b0}}, num_i} * {{NumW{1'b0}}, Recip};
  assign quot_o = prod[DivShift+PhW-1:DivShift];

endmodule
`default_nettype wire

// ===== design/ph_window_bang_bang_controller_unit.sv =====
// Path: a window-closing sample passes the input, conversion, snapshot, trim, mean and output registers.
// Throughput: one sample per cycle unless result_o stalls; one result per Samples samples.
// Stages: input reg, conversion, window accumulate, closed-window snapshot, trim, reciprocal multiply, output reg.
// Reset: async active-low; clears window count, sum and pipeline valids, loads register
// defaults (target 0, band 102, gain 291, offset 195).
`default_nettype none
module ph_window_bang_bang_controller_unit import phwbb_pkg::*; #(
  parameter int unsigned Samples = SamplesDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  phwbb_sample_if.sink    sample_i,
  phwbb_cfg_if.sink       cfg_i,
  phwbb_result_if.source  result_o
);

  localparam int unsigned Half = (Samples - 2) / 2;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target <= TargetReset;
      cfg_q.band   <= BandReset;
      cfg_q.gain   <= GainReset;
      cfg_q.offset <= OffsetReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_TARGET: cfg_q.target <= cfg_i.data[PhW-1:0];
        CFG_BAND:   cfg_q.band   <= cfg_i.data[BandW-1:0];
        CFG_GAIN:   cfg_q.gain   <= $signed(cfg_i.data[GainW-1:0]);
        CFG_OFFSET: cfg_q.offset <= $signed(cfg_i.data[OffsetW-1:0]);
        default: ;
      endcase
    end
  end

  // stage valids and readiness
  logic v1_q, v2_q, v3_q, v4_q, v5_q, ov_q;
  logic r1, r2, r3, r4, r5, r6;
  logic acc_take, close;

  assign r6 = !ov_q || result_o.ready;
  assign r5 = !v5_q || r6;
  assign r4 = !v4_q || r5;
  assign r3 = !v3_q || r4;
  assign acc_take = v2_q && (!close || r3);
  assign r2 = !v2_q || acc_take;
  assign r1 = !v1_q || r2;
  assign sample_i.ready = r1;

  // input register
  logic [AdcW-1:0] adc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (r1) begin
      v1_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && sample_i.valid) begin
      adc_q <= sample_i.adc_sample;
    end
  end

  // conversion
  logic [PhW-1:0] ph_d, ph_q;

  phwbb_convert u_convert (
    .adc_i (adc_q),
    .cfg_i (cfg_q),
    .ph_o  (ph_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (r2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      ph_q <= ph_d;
    end
  end

  // window accumulation
  logic [CountW-1:0] cnt_q;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [PhW-1:0]    low_q, low_d, high_q, high_d;
  logic              first;

  assign first = (cnt_q == '0);
  assign close = (cnt_q == CountW'(Samples - 1));
  assign sum_d = first ? {{(SumW-PhW){1'b0}}, ph_q}
                       : sum_q + {{(SumW-PhW){1'b0}}, ph_q};
  assign low_d  = (first || ph_q < low_q)  ? ph_q : low_q;
  assign high_d = (first || ph_q > high_q) ? ph_q : high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
    end else if (acc_take) begin
      cnt_q <= close ? '0 : cnt_q + 1'b1;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_take) begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  // closed-window snapshot
  logic [SumW-1:0] fsum_q;
  logic [PhW-1:0]  flow_q, fhigh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (r3) begin
      v3_q <= acc_take && close;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_take && close) begin
      fsum_q  <= sum_d;
      flow_q  <= low_d;
      fhigh_q <= high_d;
    end
  end

  // trim and rounding bias
  logic [NumW-1:0] num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (r4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r4 && v3_q) begin
      num_q <= {1'b0, fsum_q} - {{(NumW-PhW){1'b0}}, flow_q}
             - {{(NumW-PhW){1'b0}}, fhigh_q} + NumW'(Half);
    end
  end

  // mean
  logic [PhW-1:0] mean_d, mean_q;

  phwbb_divide #(
    .Samples (Samples)
  ) u_divide (
    .num_i  (num_q),
    .quot_o (mean_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (r5) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r5 && v4_q) begin
      mean_q <= mean_d;
    end
  end

  // pump decision and output register
  logic [PhW:0]   upper, mean_ext, lower_chk;
  logic           enable, acid_d, alkali_d;
  logic [PhW-1:0] avg_q;
  logic           acid_q, alkali_q;

  assign enable    = (cfg_q.target != '0);
  assign upper     = {1'b0, cfg_q.target} + {{(PhW+1-BandW){1'b0}}, cfg_q.band};
  assign mean_ext  = {1'b0, mean_q};
  assign lower_chk = mean_ext + {{(PhW+1-BandW){1'b0}}, cfg_q.band};
  assign acid_d    = enable && (mean_ext > upper);
  assign alkali_d  = enable && !acid_d && (lower_chk < {1'b0, cfg_q.target});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (r6) begin
      ov_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r6 && v5_q) begin
      avg_q    <= mean_q;
      acid_q   <= acid_d;
      alkali_q <= alkali_d;
    end
  end

  assign result_o.valid      = ov_q;
  assign result_o.ph_average = avg_q;
  assign result_o.acid_on    = acid_q;
  assign result_o.base_on    = alkali_q;

endmodule
`default_nettype wire

// ===== design/phwbb_checker.sv =====
`default_nettype none
module phwbb_checker import phwbb_pkg::*; (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           res_valid_i,
  input wire logic           res_ready_i,
  input wire logic [PhW-1:0] res_avg_i,
  input wire logic           res_acid_i,
  input wire logic           res_alkali_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result valid dropped under stall");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      $stable(res_avg_i) && $stable(res_acid_i) && $stable(res_alkali_i))
    else $error("result payload changed under stall");

  a_pumps_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !(res_acid_i && res_alkali_i))
    else $error("acid and alkali pumps both on");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !res_valid_i)
    else $error("result valid during reset");

endmodule

bind ph_window_bang_bang_controller_unit phwbb_checker u_phwbb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .res_avg_i    (result_o.ph_average),
  .res_acid_i   (result_o.acid_on),
  .res_alkali_i (result_o.base_on)
);
`default_nettype wire
